@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the rotary wheel event unit.
// Every macro samples on clk; the reset-qualified form also expects rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, switched off while rst_n is low.
`define AST_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/rwe_pkg.sv @@
// Package for the rotary wheel event unit: event codes, register indexes,
// field widths and register reset values. No dependencies.
`default_nettype none

package rwe_pkg;

  localparam int unsigned EV_W      = 3;
  localparam int unsigned PEND_W    = 8;
  localparam int unsigned DEB_W     = 4;
  localparam int unsigned LONG_W    = 10;
  localparam int unsigned IDLE_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 15;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 3'd0,
    EV_RIGHT = 3'd1,
    EV_LEFT  = 3'd2,
    EV_PRESS = 3'd3,
    EV_LONG  = 3'd4,
    EV_SLEEP = 3'd5
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_IDLE       = 2'd2
  } cfg_idx_t;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 4'd3;
  localparam logic [LONG_W-1:0] LONG_PRESS_RST = 10'd500;
  localparam logic [IDLE_W-1:0] IDLE_RST       = 15'd20000;

endpackage

`default_nettype wire

@@ design/rotary_wheel_event_unit.sv @@
// Rotary wheel event unit: quadrature decode, button debounce and event pick.
// Depends on rwe_pkg and on assert_macros.svh for its assertions.
//
// Usage: feed one word per one-millisecond tick on the in_ channel; each
// word carries the sampled levels of encoder pins A and B, the button level
// (1 released, 0 pressed) and a flush flag that empties both turn queues.
// For every accepted input word exactly one result word leaves on the out_
// channel: the event of that tick (none, right, left, press, long press or
// sleep) and the low eight bits of both pending turn queues after the tick.
// The sample is captured in an input register, then the decode, button
// machine and event choice run in one pass of logic into the result
// register, together with the state update.
// Throughput is one word per cycle while out_tready holds; the state loop
// closes in the same pass of logic, so a new sample can follow every clock.
// If the receiver stalls, the result register holds its word, the input
// register fills, and in_tready drops until out_tready returns.
// The cfg_ port writes the debounce, long press and idle limits. It is to be
// written only while no word is in flight; the block does not enforce it.
// Synchronous active-low reset empties both stages, clears the queues and
// counters, puts the button in its disarmed phase and loads the register
// defaults (debounce 3, long press 500, idle 20000 ticks).
`default_nettype none

module rotary_wheel_event_unit #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // in_tdata: [0] pin_a, [1] pin_b, [2] pin_button, [3] flush, [7:4] zero
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [rwe_pkg::IN_DATA_W-1:0]       in_tdata,
  // out_tdata: [2:0] event_res, [10:3] pending_right, [18:11] pending_left,
  // [23:19] zero
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [rwe_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire                                 cfg_we,
  input  wire  [rwe_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire  [rwe_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

  import rwe_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned PW = (COUNT_WIDTH > PEND_W) ? COUNT_WIDTH : PEND_W;
  localparam logic [COUNT_WIDTH-1:0] Q_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [LONG_W-1:0] TMR_MAX = {LONG_W{1'b1}};
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

  typedef enum logic [2:0] {
    PH_DISARMED = 3'd0,
    PH_CONFIRM  = 3'd1,
    PH_ARMED    = 3'd2,
    PH_DEBOUNCE = 3'd3,
    PH_HELD     = 3'd4
  } phase_t;

  // Configuration registers.
  logic [DEB_W-1:0]  deb_ticks_r;
  logic [LONG_W-1:0] long_ticks_r;
  logic [IDLE_W-1:0] idle_ticks_r;

  // Input stage.
  logic s1_valid_r;
  logic s1_a_r, s1_b_r, s1_rel_r, s1_flush_r;

  // Block state.
  logic                   last_a_r, last_b_r;
  logic [COUNT_WIDTH-1:0] right_q_r, left_q_r;
  phase_t                 phase_r;
  logic [LONG_W-1:0]      btn_timer_r;
  logic [IDLE_W-1:0]      idle_cnt_r;

  // Result stage.
  logic              out_valid_r;
  ev_t               out_ev_r;
  logic [PEND_W-1:0] out_right_r, out_left_r;

  // Next values.
  logic [COUNT_WIDTH-1:0] right_q_nxt, left_q_nxt;
  phase_t                 phase_nxt;
  logic [LONG_W-1:0]      btn_timer_nxt;
  logic [IDLE_W-1:0]      idle_cnt_nxt;
  ev_t                    ev_nxt;

  // Intermediate decode signals.
  logic                   rise_a, rise_b;
  logic [1:0]             inc_right, inc_left;
  logic [COUNT_WIDTH:0]   sum_right, sum_left;
  logic [COUNT_WIDTH-1:0] right_sat, left_sat, right_fl, left_fl;
  ev_t                    btn_ev;
  logic [LONG_W-1:0]      long_lim, held_cnt;
  logic [IDLE_W-1:0]      idle_lim, idle_inc;
  logic [PW-1:0]          right_ext, left_ext;

  logic out_free, fire;

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // Quadrature decode: each rising edge is judged against the new level of
  // the other pin, so both edges in one tick can queue two turns.
  always_comb begin
    rise_a    = s1_a_r && !last_a_r;
    rise_b    = s1_b_r && !last_b_r;
    inc_right = {1'b0, rise_a && !s1_b_r} + {1'b0, rise_b && !s1_a_r};
    inc_left  = {1'b0, rise_a && s1_b_r} + {1'b0, rise_b && s1_a_r};
    sum_right = {1'b0, right_q_r} + (COUNT_WIDTH+1)'(inc_right);
    sum_left  = {1'b0, left_q_r} + (COUNT_WIDTH+1)'(inc_left);
    right_sat = (sum_right > {1'b0, Q_MAX}) ? Q_MAX : sum_right[COUNT_WIDTH-1:0];
    left_sat  = (sum_left > {1'b0, Q_MAX}) ? Q_MAX : sum_left[COUNT_WIDTH-1:0];
    right_fl  = s1_flush_r ? '0 : right_sat;
    left_fl   = s1_flush_r ? '0 : left_sat;
  end

  // Button machine.
  always_comb begin
    phase_nxt     = phase_r;
    btn_timer_nxt = btn_timer_r;
    btn_ev        = EV_NONE;
    long_lim      = (long_ticks_r == '0) ? LONG_W'(1) : long_ticks_r;
    held_cnt      = (btn_timer_r < TMR_MAX) ? btn_timer_r + LONG_W'(1) : btn_timer_r;
    unique case (phase_r)
      PH_CONFIRM: begin
        if (btn_timer_r != '0) begin
          btn_timer_nxt = btn_timer_r - LONG_W'(1);
        end else begin
          phase_nxt = s1_rel_r ? PH_ARMED : PH_DISARMED;
        end
      end
      PH_ARMED: begin
        if (!s1_rel_r) begin
          phase_nxt     = PH_DEBOUNCE;
          btn_timer_nxt = LONG_W'(deb_ticks_r);
        end
      end
      PH_DEBOUNCE: begin
        if (btn_timer_r != '0) begin
          btn_timer_nxt = btn_timer_r - LONG_W'(1);
        end else begin
          phase_nxt     = PH_HELD;
          btn_timer_nxt = '0;
        end
      end
      PH_HELD: begin
        if (s1_rel_r) begin
          btn_ev        = EV_PRESS;
          phase_nxt     = PH_ARMED;
          btn_timer_nxt = '0;
        end else if (held_cnt >= long_lim) begin
          btn_ev        = EV_LONG;
          phase_nxt     = PH_DISARMED;
          btn_timer_nxt = '0;
        end else begin
          btn_timer_nxt = held_cnt;
        end
      end
      default: begin
        // Disarmed, and any code that means nothing: wait for a release.
        if (s1_rel_r) begin
          phase_nxt     = PH_CONFIRM;
          btn_timer_nxt = LONG_W'(deb_ticks_r);
        end else begin
          phase_nxt = PH_DISARMED;
        end
      end
    endcase
  end

  // Event choice: button first, then right, then left, then sleep.
  always_comb begin
    right_q_nxt  = right_fl;
    left_q_nxt   = left_fl;
    idle_lim     = (idle_ticks_r == '0) ? IDLE_W'(1) : idle_ticks_r;
    idle_inc     = (idle_cnt_r < IDLE_MAX) ? idle_cnt_r + IDLE_W'(1) : idle_cnt_r;
    idle_cnt_nxt = '0;
    ev_nxt       = btn_ev;
    if (btn_ev == EV_NONE) begin
      if (right_fl != '0) begin
        right_q_nxt = right_fl - COUNT_WIDTH'(1);
        ev_nxt      = EV_RIGHT;
      end else if (left_fl != '0) begin
        left_q_nxt = left_fl - COUNT_WIDTH'(1);
        ev_nxt     = EV_LEFT;
      end else if (idle_inc >= idle_lim) begin
        ev_nxt = EV_SLEEP;
      end else begin
        idle_cnt_nxt = idle_inc;
      end
    end
    right_ext = PW'(right_q_nxt);
    left_ext  = PW'(left_q_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_ticks_r  <= DEBOUNCE_RST;
      long_ticks_r <= LONG_PRESS_RST;
      idle_ticks_r <= IDLE_RST;
      s1_valid_r   <= 1'b0;
      last_a_r     <= 1'b0;
      last_b_r     <= 1'b0;
      right_q_r    <= '0;
      left_q_r     <= '0;
      phase_r      <= PH_DISARMED;
      btn_timer_r  <= '0;
      idle_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DEBOUNCE:   deb_ticks_r  <= cfg_wdata[DEB_W-1:0];
          CFG_LONG_PRESS: long_ticks_r <= cfg_wdata[LONG_W-1:0];
          CFG_IDLE:       idle_ticks_r <= cfg_wdata[IDLE_W-1:0];
          default: ;
        endcase
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        last_a_r    <= s1_a_r;
        last_b_r    <= s1_b_r;
        right_q_r   <= right_q_nxt;
        left_q_r    <= left_q_nxt;
        phase_r     <= phase_nxt;
        btn_timer_r <= btn_timer_nxt;
        idle_cnt_r  <= idle_cnt_nxt;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_a_r     <= in_tdata[0];
      s1_b_r     <= in_tdata[1];
      s1_rel_r   <= in_tdata[2];
      s1_flush_r <= in_tdata[3];
    end
    if (fire) begin
      out_ev_r    <= ev_nxt;
      out_right_r <= right_ext[PEND_W-1:0];
      out_left_r  <= left_ext[PEND_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - EV_W - 2*PEND_W)'(0), out_left_r, out_right_r, out_ev_r};

  // A sleep is only ever reported with both queues empty.
  `AST_CLK_RST(a_sleep_queues_empty, (out_valid_r && out_ev_r == EV_SLEEP) |-> (out_right_r == '0 && out_left_r == '0), "sleep reported with turns pending")
  // Every reported event restarts the idle count.
  `AST_CLK_RST(a_idle_restart, (fire && ev_nxt != EV_NONE) |=> (idle_cnt_r == '0), "idle count not restarted after an event")
  // A long press always leaves the button disarmed.
  `AST_CLK_RST(a_long_disarms, (fire && ev_nxt == EV_LONG) |=> (phase_r == PH_DISARMED), "long press did not disarm the button")
  // An armed button never has a timer running.
  `AST_CLK_RST(a_armed_timer_idle, (phase_r == PH_ARMED) |-> (btn_timer_r == '0), "timer running while armed")
  // Reset empties both stages.
  `AST_CLK(a_reset_empties, !rst_n |=> (!s1_valid_r && !out_valid_r), "stage valid after reset")

endmodule

`default_nettype wire
